/* rtl/lts_pkg.sv */
// Package for the two-line scrolling LCD terminal.
// Holds character codes, display commands and the store control struct; no dependencies.
`default_nettype none

package lts_pkg;

   localparam int LINE_WIDTH_DEFAULT = 16;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_DDRAM = 8'h80;
   localparam logic [7:0] LINE2_ADDR = 8'h40;
   localparam logic [7:0] CMD_LINE2 = CMD_DDRAM | LINE2_ADDR;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

`default_nettype wire

/* rtl/lts_line_store.sv */
// Line store of the scrolling terminal: one write port, one registered read port.
// Entries never written read as zero through per-entry valid bits. Uses lts_pkg.
`default_nettype none

module lts_line_store #(
   parameter int LINE_WIDTH = lts_pkg::LINE_WIDTH_DEFAULT,
   parameter int IDX_W      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lts_pkg::store_ctl_type ctl,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire logic [7:0]           wr_data,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output logic [7:0]                rd_data
);
   import lts_pkg::*;

   logic [7:0]            mem [LINE_WIDTH];
   logic [LINE_WIDTH-1:0] vld_ff;
   logic [7:0]            mem_rd_ff;
   logic                  vld_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            vld_rd_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = vld_rd_ff ? mem_rd_ff : 8'h00;

endmodule

`default_nettype wire

/* rtl/lcd_two_line_scroll_terminal.sv */
// Two-line scrolling terminal for a character LCD: turns each character into
// a run of command/data beats. A printable character takes one output beat, a
// carriage return one beat; a newline or a character on a full line takes a
// clear beat, one redraw beat per recorded character, a line-2 beat and, for
// a printable character, the character beat. The input is stalled for the
// whole run, and a redraw is paced by the single registered read port of
// the line store (one read, then one beat, per character).
// The sequencer's one counter and compare walk the store entry by entry.
// Depends on lts_pkg and lts_line_store.
`default_nettype none

module lcd_two_line_scroll_terminal #(
   parameter int LINE_WIDTH = lts_pkg::LINE_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_is_data,
   output logic [7:0]      rsp_lcd_byte,
   output logic            rsp_last_of_run
);
   import lts_pkg::*;

   localparam int CNT_W = $clog2(LINE_WIDTH + 1);
   localparam int IDX_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
   localparam logic [CNT_W-1:0] LW = CNT_W'(LINE_WIDTH);

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_READ, S_DATA, S_LINE2, S_CHAR
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       char_ff, char_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] rec_ff, rec_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_is_data_ff, rsp_is_data_in;
   logic [7:0]       rsp_lcd_byte_ff, rsp_lcd_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   store_ctl_type    ctl;
   logic [7:0]       rd_data;
   logic             out_free;
   logic             accept;
   logic [CNT_W-1:0] rec_max;
   logic [CNT_W-1:0] idx_next;

   lts_line_store #(
      .LINE_WIDTH(LINE_WIDTH),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .wr_addr(cur_ff[IDX_W-1:0]),
      .wr_data(char_ff),
      .rd_addr(idx_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rec_max   = (rec_ff < cur_ff) ? cur_ff : rec_ff;
   assign idx_next  = idx_ff + CNT_W'(1);

   always_comb begin
      state_in        = state_ff;
      char_in         = char_ff;
      cur_in          = cur_ff;
      rec_in          = rec_ff;
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_data_in  = rsp_is_data_ff;
      rsp_lcd_byte_in = rsp_lcd_byte_ff;
      rsp_last_in     = rsp_last_ff;
      ctl             = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               char_in = req_char_in;
               if (req_char_in == CH_CR) begin
                  state_in = S_LINE2;
               end else if (req_char_in == CH_LF || cur_ff >= LW) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_CHAR;
               end
            end
         end
         S_CLEAR: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_data_in  = 1'b0;
               rsp_lcd_byte_in = CMD_CLEAR;
               rsp_last_in     = 1'b0;
               rec_in          = (rec_max > LW) ? LW : rec_max;
               idx_in          = '0;
               state_in        = (rec_max == '0) ? S_LINE2 : S_READ;
            end
         end
         S_READ: begin
            ctl.rd_en = 1'b1;
            state_in  = S_DATA;
         end
         S_DATA: begin
            // read data holds in the store until the next read
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_data_in  = 1'b1;
               rsp_lcd_byte_in = rd_data;
               rsp_last_in     = 1'b0;
               idx_in          = idx_next;
               state_in        = (idx_next >= rec_ff) ? S_LINE2 : S_READ;
            end
         end
         S_LINE2: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_data_in  = 1'b0;
               rsp_lcd_byte_in = CMD_LINE2;
               rsp_last_in     = (char_ff == CH_CR) || (char_ff == CH_LF);
               cur_in          = '0;
               if (char_ff == CH_CR) begin
                  if (rec_ff == '0) begin
                     rec_in = cur_ff;
                  end
                  state_in = S_IDLE;
               end else begin
                  rec_in   = '0;
                  state_in = (char_ff == CH_LF) ? S_IDLE : S_CHAR;
               end
            end
         end
         S_CHAR: begin
            if (out_free) begin
               ctl.wr_en       = 1'b1;
               cur_in          = cur_ff + CNT_W'(1);
               rsp_valid_in    = 1'b1;
               rsp_is_data_in  = 1'b1;
               rsp_lcd_byte_in = char_ff;
               rsp_last_in     = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         rec_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rec_ff       <= rec_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff         <= char_in;
      rsp_is_data_ff  <= rsp_is_data_in;
      rsp_lcd_byte_ff <= rsp_lcd_byte_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_data     = rsp_is_data_ff;
   assign rsp_lcd_byte    = rsp_lcd_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire
